>>> rtl/scl_pkg.sv
// ---------------------------------------------------------------------------
// scl_pkg - shared types and constants for the sorted character list
// Store size, count width, beat payloads and the cell control bundle.
// ---------------------------------------------------------------------------
package scl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    typedef struct packed {
        action_t           action;
        logic signed [7:0] value;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic              wr_en;
        action_t           action;
        logic signed [7:0] value;
    } cell_ctl_t;

endpackage

>>> rtl/scl_cell.sv
// ---------------------------------------------------------------------------
// scl_cell - one slot of the sorted character list
// Holds one entry, compares it against the broadcast value and takes the
// broadcast value or a neighbour's entry when the list opens or closes.
// ---------------------------------------------------------------------------
module scl_cell (
    input  logic                     clk,
    input  scl_pkg::cell_ctl_t       ctl,
    input  logic                     occupied,
    input  logic                     left_gt,
    input  logic signed [7:0]        left_entry,
    input  logic signed [7:0]        right_entry,
    input  logic                     found_in,
    output logic                     gt,
    output logic                     found_out,
    output logic signed [7:0]        entry
);
    import scl_pkg::*;

    logic signed [7:0] entry_reg;
    logic signed [7:0] entry_next;
    logic              eq;

    // entries are ascending, so gt forms a prefix of the row
    assign gt        = occupied && (ctl.value > entry_reg);
    assign eq        = occupied && (ctl.value == entry_reg);
    assign found_out = found_in | eq;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.wr_en && !gt)
        begin
            case (ctl.action)
                ACT_INSERT:
                begin
                    if (left_gt)
                        entry_next = ctl.value;
                    else
                        entry_next = left_entry;
                end
                ACT_DELETE: entry_next = right_entry;
                default:    entry_next = entry_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/sorted_char_list.sv
// ---------------------------------------------------------------------------
// sorted_char_list - bounded ascending store of signed characters
// Insert and delete of signed 8-bit values over a row of compare cells.
// ---------------------------------------------------------------------------
// One command beat in, one response beat out, one beat per clock sustained.
// Every slot compares the broadcast value against its entry in the same
// cycle, so an insert or delete completes in the cycle it is accepted and
// its response appears on rsp in the next cycle; the only thing that holds
// cmd back is a full response register whose beat rsp_stall refuses. An
// insert lands before the first entry not smaller than it (ahead of any
// equal entries); a full store refuses it with ST_FULL. A delete
// removes the lowest-positioned equal entry or answers ST_NOT_FOUND. Each
// response carries the count after the operation and an empty flag. No
// clearing pass follows reset: slots beyond the count are never looked at.
// ---------------------------------------------------------------------------
module sorted_char_list (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  scl_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scl_pkg::rsp_t  rsp
);
    import scl_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              cmd_acc;
    logic              full;
    logic              found;
    logic              do_ins;
    logic              do_del;
    cell_ctl_t         ctl;

    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      gt;
    logic [CAPACITY:0]        found_chain;
    logic signed [7:0]        entry [CAPACITY];

    // response register frees the command side whenever it is empty or drains
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign cmd_acc   = cmd_valid && !cmd_stall;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign found  = found_chain[CAPACITY];
    assign do_ins = (cmd.action == ACT_INSERT) && !full;
    assign do_del = (cmd.action == ACT_DELETE) && found;

    assign ctl.wr_en  = cmd_acc && (do_ins || do_del);
    assign ctl.action = cmd.action;
    assign ctl.value  = cmd.value;

    // first-match flag ripples along the row
    assign found_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic              left_gt;
            logic signed [7:0] left_entry;
            logic signed [7:0] right_entry;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_gt    = 1'b1;
                assign left_entry = cmd.value;
            end
            else
            begin : g_body
                assign left_gt    = gt[gi-1];
                assign left_entry = entry[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = entry[gi];
            end
            else
            begin : g_mid
                assign right_entry = entry[gi+1];
            end

            scl_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occ[gi]),
                .left_gt     (left_gt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .found_in    (found_chain[gi]),
                .gt          (gt[gi]),
                .found_out   (found_chain[gi+1]),
                .entry       (entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (cmd_acc)
        begin
            rsp_valid_next = 1'b1;
            case (cmd.action)
                ACT_INSERT:
                begin
                    if (full)
                        rsp_next.status = ST_FULL;
                    else
                    begin
                        rsp_next.status = ST_DONE;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                ACT_DELETE:
                begin
                    if (found)
                    begin
                        rsp_next.status = ST_DONE;
                        count_next      = count_reg - CNT_W'(1);
                    end
                    else
                        rsp_next.status = ST_NOT_FOUND;
                end
                default: rsp_next.status = ST_NOT_FOUND;
            endcase
            rsp_next.entry_count = COUNT_W'(count_next);
            rsp_next.is_empty    = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // -----------------------------------------------------------------------
    // checks
    // -----------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (cmd.action == ACT_INSERT) && full) |=> $stable(count_reg))
        else $error("refused insert changed the count");

    a_beat_answered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> rsp_valid)
        else $error("accepted command gave no response");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with stored count");

endmodule
